[sv/kns_pkg.sv]
package kns_pkg;

	// default accumulator width request, clipped to MAX_ACC_W inside the core
	localparam int VALUE_BITS_DEF = 48;
	localparam int MAX_ACC_W      = 48;
	localparam int MAX_W          = 49;

	// key window: twelve bytes, oldest byte in the top lane
	// key bytes: quoted identifier name then a colon
	localparam int KEY_LEN = 12;
	localparam int KEY_W   = KEY_LEN * 8;
	localparam logic [KEY_W-1:0] KEY_BYTES = 96'h2275_7064_6174_655f_6964_223a;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// scan phases
	typedef enum logic [2:0] {
		PH_SEARCH = 3'b001,
		PH_SKIP   = 3'b010,
		PH_DIGITS = 3'b100
	} phase_t;

	// one byte handed to the scan core
	typedef struct packed {
		logic       en;
		logic [7:0] text_byte;
		logic       body_end;
	} step_t;

	// what the core would report if this byte closes the body
	typedef struct packed {
		logic signed [MAX_W-1:0] max_value;
		logic                    raised;
	} result_t;

endpackage

[sv/kns_if.sv]
interface kns_in_if import kns_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       body_end;

	modport source (output valid, output text_byte, output body_end, input ready);
	modport sink (input valid, input text_byte, input body_end, output ready);
endinterface

interface kns_out_if import kns_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [MAX_W-1:0] max_value;
	logic                    raised;

	modport source (output valid, output max_value, output raised, input ready);
	modport sink (input valid, input max_value, input raised, output ready);
endinterface

[sv/kns_scan_core.sv]
module kns_scan_core import kns_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  step_t                   step,
	input  logic signed [MAX_W-1:0] start_max,
	output result_t                 result
);

	localparam int ACC_W = (VALUE_BITS > MAX_ACC_W) ? MAX_ACC_W : VALUE_BITS;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	logic [KEY_W-1:0]        window_q;
	phase_t                  phase_q;
	logic [ACC_W-1:0]        digit_q;
	logic signed [MAX_W-1:0] run_max_q;
	logic                    body_start_q;

	logic [KEY_W-1:0]        win_base;
	logic [KEY_W-1:0]        win_next;
	phase_t                  phase_cur;
	phase_t                  phase_nxt;
	logic [ACC_W-1:0]        digit_cur;
	logic [ACC_W-1:0]        digit_nxt;
	logic signed [MAX_W-1:0] rm_cur;
	logic signed [MAX_W-1:0] rm_nxt;
	logic                    is_digit;
	logic                    is_space;
	logic [7:0]              dsub;
	logic [ACC_W-1:0]        dval;
	logic [ACC_W+3:0]        acc_ext;
	logic [ACC_W+3:0]        mac;
	logic [ACC_W-1:0]        acc_next;
	logic                    search;
	logic                    close_old;
	logic                    do_close;
	logic [ACC_W-1:0]        close_val;
	logic signed [MAX_W-1:0] cand;
	logic                    gt_rm;
	logic                    gt_start_cand;
	logic                    gt_start_rm;

	// a new body starts from cleared scan state and the configured maximum
	always_comb begin
		win_base  = body_start_q ? '0 : window_q;
		phase_cur = body_start_q ? PH_SEARCH : phase_q;
		digit_cur = body_start_q ? '0 : digit_q;
		rm_cur    = body_start_q ? start_max : run_max_q;
		win_next  = {win_base[KEY_W-9:0], step.text_byte};
	end

	// byte class and digit value
	always_comb begin
		is_digit = (step.text_byte >= CHAR_ZERO) && (step.text_byte <= CHAR_NINE);
		is_space = (step.text_byte == CHAR_SPACE);
		dsub     = step.text_byte - CHAR_ZERO;
		dval     = {{(ACC_W-4){1'b0}}, dsub[3:0]};
	end

	// times ten plus digit as shift-add, saturating when the top bits spill
	always_comb begin
		acc_ext  = {4'b0000, digit_cur};
		mac      = (acc_ext << 3) + (acc_ext << 1) + {4'b0000, dval};
		acc_next = (|mac[ACC_W+3:ACC_W]) ? ACC_MAX : mac[ACC_W-1:0];
	end

	// phase sequencing
	always_comb begin
		phase_nxt = PH_SEARCH;
		digit_nxt = digit_cur;
		search    = 1'b0;
		close_old = 1'b0;
		unique case (phase_cur)
			PH_SKIP: begin
				if (is_space) begin
					phase_nxt = PH_SKIP;
				end else if (is_digit) begin
					phase_nxt = PH_DIGITS;
					digit_nxt = dval;
				end else begin
					search = 1'b1;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					phase_nxt = PH_DIGITS;
					digit_nxt = acc_next;
				end else begin
					close_old = 1'b1;
					search    = 1'b1;
				end
			end
			default: begin
				search = 1'b1;
			end
		endcase
		// the terminating byte may itself complete a key
		if (search && (win_next == KEY_BYTES)) begin
			phase_nxt = PH_SKIP;
			digit_nxt = '0;
		end
	end

	// at most one number closes per byte: on its terminator or at body end
	always_comb begin
		do_close      = close_old || (step.body_end && (phase_nxt == PH_DIGITS));
		close_val     = close_old ? digit_cur : digit_nxt;
		cand          = $signed({{(MAX_W-ACC_W){1'b0}}, close_val});
		gt_rm         = do_close && (cand > rm_cur);
		gt_start_cand = cand > start_max;
		gt_start_rm   = rm_cur > start_max;
		rm_nxt        = gt_rm ? cand : rm_cur;
		result.max_value = rm_nxt;
		result.raised    = gt_rm ? gt_start_cand : gt_start_rm;
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SEARCH;
			body_start_q <= 1'b1;
		end else if (step.en) begin
			phase_q      <= phase_nxt;
			body_start_q <= step.body_end;
		end
	end

	always_ff @(posedge clk) begin
		if (step.en) begin
			window_q  <= win_next;
			digit_q   <= digit_nxt;
			run_max_q <= rm_nxt;
		end
	end

	// checks
	a_skip_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!body_start_q && phase_q == PH_SKIP) |-> (digit_q == '0))
		else $error("digit accumulator not clear while skipping spaces");

	a_max_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!body_start_q |=> (run_max_q >= $past(run_max_q)))
		else $error("running maximum fell within a body");

	a_max_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		(step.en && body_start_q) |=> (run_max_q >= $past(start_max)))
		else $error("running maximum below starting value after body start");

endmodule

[sv/keyed_number_max_scanner.sv]
// Scans a byte stream for a fixed twelve-byte key (a quoted identifier name and a colon)
// and reports, on the last byte of each body, the largest decimal number that followed
// the key (spaces after the key are skipped, values saturate at 2^min(VALUE_BITS,48)-1),
// seeded from start_max, together with a flag that the maximum rose above start_max.
// One byte is taken every cycle while the input does not stall; each byte is held in the
// input register, and its scan update is done in a single pass into the result register,
// which loads as the final byte of a body leaves the input register. The input stalls
// only when a finished result is still waiting to be taken and the byte in the input
// register ends another body. start_max is sampled at the first and the last byte of
// each body and should be written between bodies.
module keyed_number_max_scanner import kns_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	kns_in_if.sink                  body,
	kns_out_if.source               result,
	input  logic                    cfg_we,
	input  logic signed [MAX_W-1:0] cfg_wdata
);

	logic signed [MAX_W-1:0] start_max_q;
	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    end_s1;
	logic                    out_valid_q;
	result_t                 out_res_q;
	logic                    slot_free;
	logic                    adv;
	step_t                   step;
	result_t                 core_res;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_max_q <= '1;
		end else if (cfg_we) begin
			start_max_q <= cfg_wdata;
		end
	end

	// a byte moves on unless it closes a body while the result slot is full
	assign slot_free  = !out_valid_q || result.ready;
	assign adv        = valid_s1 && (!end_s1 || slot_free);
	assign body.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.valid && body.ready) begin
			byte_s1 <= body.text_byte;
			end_s1  <= body.body_end;
		end
	end

	// scan core
	always_comb begin
		step.en        = adv;
		step.text_byte = byte_s1;
		step.body_end  = end_s1;
	end

	kns_scan_core #(
		.VALUE_BITS(VALUE_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.start_max(start_max_q),
		.result   (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && end_s1) begin
			out_res_q <= core_res;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.max_value = out_res_q.max_value;
	assign result.raised    = out_res_q.raised;

	// checks
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!body.ready |-> (valid_s1 && end_s1 && out_valid_q))
		else $error("input stalled without a pending body end and full slot");

	a_end_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && end_s1) |=> out_valid_q)
		else $error("body end transaction did not load the result register");

	a_mid_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !end_s1) |-> body.ready)
		else $error("mid-body byte held in the input register");

endmodule
